/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/lss_pkg.sv */
// Types and codes shared by the LIFO stack controller and datapath.
package lss_pkg;

    // Request operation codes; codes 6 and 7 are unused and act as no-ops.
    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_SORT    = 3'd4,
        OP_REVERSE = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Micro-operations that the controller issues to the datapath.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_PUSH,
        DP_POP,
        DP_CLEAR,
        DP_RD_TOP,
        DP_SORT_INIT,
        DP_SORT_RD0,
        DP_SORT_LD,
        DP_SORT_RDN,
        DP_SORT_STEP,
        DP_SORT_TAIL,
        DP_REV_INIT,
        DP_REV_RD_LO,
        DP_REV_RD_HI,
        DP_REV_WR_LO,
        DP_REV_WR_HI
    } dp_op_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PEEK,
        S_SORT_CHK,
        S_SORT_LD,
        S_SORT_ICHK,
        S_SORT_CMP,
        S_REV_CHK,
        S_REV_RH,
        S_REV_WL,
        S_REV_WH
    } state_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        dp_op_t  op;
        logic    res_load;
        logic    res_peek;
        status_t res_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic pass_more;
        logic step_more;
        logic rev_more;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/lss_ctrl.sv */
// Controller state machine of the LIFO stack: decodes requests and sequences sort and reverse.
module lss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [2:0]        req_type,
    input  lss_pkg::dp_stat_t stat,
    output logic              s_tready,
    output lss_pkg::cmd_t     cmd
);
    import lss_pkg::*;

    state_t state_reg;
    state_t state_next;
    op_t    req_op;
    logic   accept;

    assign req_op = op_t'(req_type);
    assign accept = s_tvalid && s_tready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (req_op)
                        OP_PEEK:    state_next = stat.empty ? S_IDLE : S_PEEK;
                        OP_SORT:    state_next = S_SORT_CHK;
                        OP_REVERSE: state_next = S_REV_CHK;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_PEEK:      state_next = S_IDLE;
            S_SORT_CHK:  state_next = stat.pass_more ? S_SORT_LD : S_IDLE;
            S_SORT_LD:   state_next = S_SORT_ICHK;
            S_SORT_ICHK: state_next = stat.step_more ? S_SORT_CMP : S_SORT_CHK;
            S_SORT_CMP:  state_next = S_SORT_ICHK;
            S_REV_CHK:   state_next = stat.rev_more ? S_REV_RH : S_IDLE;
            S_REV_RH:    state_next = S_REV_WL;
            S_REV_WL:    state_next = S_REV_WH;
            S_REV_WH:    state_next = S_REV_CHK;
            default:     state_next = S_IDLE;
        endcase
    end

    // Output logic: handshake and datapath commands.
    always_comb begin
        s_tready       = 1'b0;
        cmd.op         = DP_NOP;
        cmd.res_load   = 1'b0;
        cmd.res_peek   = 1'b0;
        cmd.res_status = ST_DONE;
        case (state_reg)
            S_IDLE: begin
                s_tready = stat.out_free;
                if (s_tvalid && stat.out_free) begin
                    case (req_op)
                        OP_PUSH: begin
                            cmd.res_load = 1'b1;
                            if (stat.full) begin
                                cmd.res_status = ST_FULL;
                            end else begin
                                cmd.op = DP_PUSH;
                            end
                        end
                        OP_POP: begin
                            cmd.res_load = 1'b1;
                            if (stat.empty) begin
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                cmd.op = DP_POP;
                            end
                        end
                        OP_PEEK: begin
                            if (stat.empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                cmd.op = DP_RD_TOP;
                            end
                        end
                        OP_CLEAR: begin
                            cmd.op       = DP_CLEAR;
                            cmd.res_load = 1'b1;
                        end
                        OP_SORT:    cmd.op = DP_SORT_INIT;
                        OP_REVERSE: cmd.op = DP_REV_INIT;
                        default:    cmd.res_load = 1'b1;
                    endcase
                end
            end
            S_PEEK: begin
                cmd.res_load = 1'b1;
                cmd.res_peek = 1'b1;
            end
            S_SORT_CHK: begin
                if (stat.pass_more) begin
                    cmd.op = DP_SORT_RD0;
                end else begin
                    cmd.res_load = 1'b1;
                end
            end
            S_SORT_LD:   cmd.op = DP_SORT_LD;
            S_SORT_ICHK: cmd.op = stat.step_more ? DP_SORT_RDN : DP_SORT_TAIL;
            S_SORT_CMP:  cmd.op = DP_SORT_STEP;
            S_REV_CHK: begin
                if (stat.rev_more) begin
                    cmd.op = DP_REV_RD_LO;
                end else begin
                    cmd.res_load = 1'b1;
                end
            end
            S_REV_RH:    cmd.op = DP_REV_RD_HI;
            S_REV_WL:    cmd.op = DP_REV_WR_LO;
            S_REV_WH:    cmd.op = DP_REV_WR_HI;
            default:     cmd.op = DP_NOP;
        endcase
    end

endmodule

/* rtl/lss_dp.sv */
// Datapath of the LIFO stack: entry memory, count, sort and reverse pointers, result register.
module lss_dp #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lss_pkg::cmd_t      cmd,
    input  logic signed [31:0] push_value,
    input  logic               m_tready,
    output lss_pkg::dp_stat_t  stat,
    output logic               m_tvalid,
    output logic signed [31:0] top_value,
    output logic [1:0]         status,
    output logic [4:0]         entry_count
);
    import lss_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Entry memory, index 0 at the bottom.
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic signed [31:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  pass_reg, pass_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic signed [31:0] carry_reg, carry_next;
    logic signed [31:0] tmp_reg, tmp_next;
    logic [CNT_W:0]    step_sum;
    logic [31:0]       count_wide;

    logic               m_valid_reg;
    logic signed [31:0] top_reg;
    logic [1:0]         status_reg;
    logic [4:0]         ec_reg;

    assign cnt_m1     = count_reg - CNT_W'(1);
    assign step_sum   = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(pass_reg);
    assign count_wide = 32'(count_next);

    // Micro-operation decode: memory port controls and next values.
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = carry_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        count_next = count_reg;
        pass_next  = pass_reg;
        idx_next   = idx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        carry_next = carry_reg;
        tmp_next   = tmp_reg;
        case (cmd.op)
            DP_PUSH: begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[ADDR_W-1:0];
                wr_data    = push_value;
                count_next = count_reg + CNT_W'(1);
            end
            DP_POP:   count_next = cnt_m1;
            DP_CLEAR: count_next = '0;
            DP_RD_TOP: begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[ADDR_W-1:0];
            end
            DP_SORT_INIT: pass_next = CNT_W'(1);
            DP_SORT_RD0: begin
                rd_en    = 1'b1;
                rd_addr  = '0;
                idx_next = '0;
            end
            DP_SORT_LD: carry_next = rdata_reg;
            DP_SORT_RDN: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg + ADDR_W'(1);
            end
            DP_SORT_STEP: begin
                // The greater word settles lower; the smaller one moves on up.
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (rdata_reg > carry_reg) begin
                    wr_data = rdata_reg;
                end else begin
                    wr_data    = carry_reg;
                    carry_next = rdata_reg;
                end
                idx_next = idx_reg + ADDR_W'(1);
            end
            DP_SORT_TAIL: begin
                wr_en     = 1'b1;
                wr_addr   = idx_reg;
                wr_data   = carry_reg;
                pass_next = pass_reg + CNT_W'(1);
            end
            DP_REV_INIT: begin
                lo_next = '0;
                hi_next = (count_reg == '0) ? '0 : cnt_m1[ADDR_W-1:0];
            end
            DP_REV_RD_LO: begin
                rd_en   = 1'b1;
                rd_addr = lo_reg;
            end
            DP_REV_RD_HI: begin
                rd_en    = 1'b1;
                rd_addr  = hi_reg;
                tmp_next = rdata_reg;
            end
            DP_REV_WR_LO: begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = rdata_reg;
            end
            DP_REV_WR_HI: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
                lo_next = lo_reg + ADDR_W'(1);
                hi_next = hi_reg - ADDR_W'(1);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Sort and reverse working registers.
    always_ff @(posedge aclk) begin
        pass_reg  <= pass_next;
        idx_reg   <= idx_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        carry_reg <= carry_next;
        tmp_reg   <= tmp_next;
    end

    // Result register: holds one result beat until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            top_reg    <= cmd.res_peek ? rdata_reg : '0;
            status_reg <= cmd.res_status;
            ec_reg     <= count_wide[4:0];
        end
    end

    // Status toward the controller.
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == DEPTH_C);
    assign stat.pass_more = (pass_reg < count_reg);
    assign stat.step_more = (step_sum < (CNT_W+1)'(count_reg));
    assign stat.rev_more  = (lo_reg < hi_reg);
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid    = m_valid_reg;
    assign top_value   = top_reg;
    assign status      = status_reg;
    assign entry_count = ec_reg;

endmodule

/* rtl/lifo_stack_sort_reverse.sv */
// Top level of the bounded LIFO stack with sort and reverse.
//
// A stack of DEPTH signed 32-bit words, one request per input beat and one
// result beat per request. Push, pop and clear are handled without leaving
// the idle state, so such beats can follow each other every cycle while the
// result register is taken. A peek on a non-empty stack passes through the
// peek state because the entry memory has a registered read port; a peek on
// an empty stack answers from the idle state. Sort is a bubble sort through
// the single read and write port of the memory that leaves the smallest
// word on top. Reverse swaps pairs from both ends, reading the low then the
// high entry and writing the low then the high entry of each pair. A
// push onto a full stack is dropped and reports status full; a pop or peek on
// an empty stack reports status empty. A new request is taken only while the
// controller is idle and the result register is empty or being read.
module lifo_stack_sort_reverse #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [2:0] req_type, [34:3] push_value, [39:35] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // [31:0] top_value, [33:32] status,
                                  // [38:34] entry_count, [39] zero
);
    import lss_pkg::*;

    logic [2:0]         req_type;
    logic signed [31:0] push_value;
    logic signed [31:0] top_value;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    cmd_t               cmd;
    dp_stat_t           stat;

    // Unpack the request beat.
    assign req_type   = s_tdata[2:0];
    assign push_value = s_tdata[34:3];

    lss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (req_type),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    lss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .push_value  (push_value),
        .m_tready    (m_tready),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .top_value   (top_value),
        .status      (status),
        .entry_count (entry_count)
    );

    // Pack the result beat.
    assign m_tdata = {1'b0, entry_count, status, top_value};

endmodule

/* rtl/lss_checker.sv */
// Port checker of the LIFO stack, bound to the top level.
module lss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
`include "assert_macros.svh"
    import lss_pkg::*;

    logic        res_stall;
    logic        res_fail;
    logic [1:0]  res_status;
    logic [31:0] res_top;

    // Fields and conditions of the result beat.
    assign res_status = m_tdata[33:32];
    assign res_top    = m_tdata[31:0];
    assign res_stall  = m_tvalid && !m_tready;
    assign res_fail   = m_tvalid && (res_status != ST_DONE);

    // No result beat is offered right after reset.
    `ASSERT_CLK_RST(a_reset_no_result, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result beat holds its payload.
    `ASSERT_CLK(a_result_hold, res_stall |=> m_tvalid && $stable(m_tdata), "result changed")

    // A request is never taken while a result waits unread.
    `ASSERT_CLK(a_no_accept_stalled, res_stall |-> !s_tready, "request taken under stall")

    // The status field carries only defined codes.
    `ASSERT_CLK(a_status_code, m_tvalid |-> res_status <= ST_FULL, "undefined status code")

    // A failed request never returns a word.
    `ASSERT_CLK(a_top_zero, res_fail |-> res_top == '0, "word returned with error status")

endmodule

bind lifo_stack_sort_reverse lss_checker u_lss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/lifo_stack_sort_reverse_tb.sv */
// Self-checking testbench for the LIFO stack with sort and reverse.
`timescale 1ns / 1ps

module lifo_stack_sort_reverse_tb;
    import lss_pkg::*;

    localparam int DEPTH = 16;
    localparam int TOTAL_ITEMS = 1250;
    // Longest quiet time of the block: a sort over a full stack plus margin.
    localparam int SETTLE_CYCLES = DEPTH * DEPTH + 2 * DEPTH + 16;
    // Codes the block treats as no-ops.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [31:0] top;
        status_t     status;
        logic [4:0]  count;
    } stack_result_t;

    // Tracks the stack contents and the result beats still owed by the block.
    class stack_scoreboard;
        logic [31:0]   words [DEPTH];
        int            held;
        stack_result_t results_due [$];
        int            mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        // Applies one accepted request to the stack and queues its result.
        function void note_request(logic [2:0] op, logic [31:0] value);
            stack_result_t due;
            logic [31:0]   swap;
            int            lo;
            int            hi;
            due.top = '0;
            due.status = ST_DONE;
            case (op)
                OP_PUSH: begin
                    if (held >= DEPTH) begin
                        due.status = ST_FULL;
                    end else begin
                        words[held] = value;
                        held++;
                    end
                end
                OP_POP: begin
                    if (held == 0) due.status = ST_EMPTY;
                    else held--;
                end
                OP_PEEK: begin
                    if (held == 0) due.status = ST_EMPTY;
                    else due.top = words[held-1];
                end
                OP_CLEAR: held = 0;
                OP_SORT: begin
                    // Bubble the smaller word upward; equal words never swap.
                    for (int pass = 1; pass < held; pass++) begin
                        for (int i = 0; i + pass < held; i++) begin
                            if ($signed(words[i+1]) > $signed(words[i])) begin
                                swap = words[i];
                                words[i] = words[i+1];
                                words[i+1] = swap;
                            end
                        end
                    end
                end
                OP_REVERSE: begin
                    lo = 0;
                    hi = held - 1;
                    while (lo < hi) begin
                        swap = words[lo];
                        words[lo] = words[hi];
                        words[hi] = swap;
                        lo++;
                        hi--;
                    end
                end
                default: ;
            endcase
            due.count = 5'(held);
            results_due.push_back(due);
        endfunction

        // Compares one result beat with the oldest outstanding result.
        function void check_result(logic [39:0] beat);
            stack_result_t due;
            if (results_due.size() == 0) begin
                $error("result beat 0x%h arrived with no request outstanding", beat);
                mismatches++;
                return;
            end
            due = results_due.pop_front();
            if (beat[31:0] !== due.top) begin
                $error("top_value: expected %0d, actual %0d",
                       $signed(due.top), $signed(beat[31:0]));
                mismatches++;
            end
            if (beat[33:32] !== due.status) begin
                $error("status: expected %0d, actual %0d", due.status, beat[33:32]);
                mismatches++;
            end
            if (beat[38:34] !== due.count) begin
                $error("entry_count: expected %0d, actual %0d", due.count, beat[38:34]);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    stack_scoreboard book = new();
    int              sent = 0;
    bit              steady = 1'b0;

    lifo_stack_sort_reverse #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock generation.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Result side: check each accepted beat and stall now and then.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata);
        m_tready <= steady || ($urandom_range(99) >= 7);
    end

    // Sends one request beat, with an occasional idle gap before it.
    task automatic send_request(input logic [2:0] op, input logic [31:0] value);
        steady = (sent >= 400 && sent < 650);
        while (!steady && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_request(op, value);
        sent++;
    endtask

    // Holds the request side quiet until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (book.results_due.size() != 0) @(posedge aclk);
    endtask

    // Push values: extremes, a small pool that gives duplicates, or anything.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3, 4: return $urandom_range(8) - 4;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return OP_PUSH;
        if (roll < 55) return OP_POP;
        if (roll < 70) return OP_PEEK;
        if (roll < 74) return OP_CLEAR;
        if (roll < 84) return OP_SORT;
        if (roll < 94) return OP_REVERSE;
        if (roll < 97) return OP_SPARE_LO;
        return OP_SPARE_HI;
    endfunction

    // Stimulus.
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: operations on an empty stack, unused codes, extremes.
        send_request(OP_PEEK, $urandom());
        send_request(OP_POP, $urandom());
        send_request(OP_CLEAR, $urandom());
        send_request(OP_SORT, $urandom());
        send_request(OP_REVERSE, $urandom());
        send_request(OP_SPARE_LO, $urandom());
        send_request(OP_SPARE_HI, $urandom());
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'h7fff_ffff);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PUSH, 32'hffff_ffff);
        send_request(OP_PEEK, $urandom());
        send_request(OP_SORT, $urandom());
        send_request(OP_PEEK, $urandom());
        send_request(OP_REVERSE, $urandom());
        send_request(OP_PEEK, $urandom());
        send_request(OP_POP, $urandom());
        send_request(OP_PEEK, $urandom());
        send_request(OP_CLEAR, $urandom());
        send_request(OP_PEEK, $urandom());

        // Random sequences.
        while (sent < TOTAL_ITEMS) begin
            if (sent >= 300 && sent < 320) wait_drained();
            case ($urandom_range(9))
                // Fill to the top, push past it, then reorder and look.
                0, 1: begin
                    while (book.held < DEPTH) send_request(OP_PUSH, pick_value());
                    repeat ($urandom_range(1, 3)) send_request(OP_PUSH, pick_value());
                    send_request(OP_PEEK, $urandom());
                    send_request(OP_SORT, $urandom());
                    send_request(OP_PEEK, $urandom());
                    send_request(OP_REVERSE, $urandom());
                    send_request(OP_PEEK, $urandom());
                end
                // Drain to empty and go one past it.
                2: begin
                    while (book.held > 0) begin
                        if ($urandom_range(3) == 0) send_request(OP_PEEK, $urandom());
                        else send_request(OP_POP, $urandom());
                    end
                    send_request(OP_POP, $urandom());
                    send_request(OP_PEEK, $urandom());
                end
                // A short run of pushes, sorted, read back from the top, then reversed.
                3, 4: begin
                    repeat ($urandom_range(1, 6)) send_request(OP_PUSH, pick_value());
                    send_request(OP_SORT, $urandom());
                    repeat ($urandom_range(1, 4)) begin
                        send_request(OP_PEEK, $urandom());
                        send_request(OP_POP, $urandom());
                    end
                    send_request(OP_REVERSE, $urandom());
                    send_request(OP_PEEK, $urandom());
                end
                // Quiet request side, then a few random requests.
                9: begin
                    wait_drained();
                    repeat (8) send_request(pick_op(), pick_value());
                end
                default: begin
                    repeat (24) send_request(pick_op(), pick_value());
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // Let every owed result arrive, then watch for stray beats.
        while (book.results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (book.mismatches == 0 && book.results_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
